### rtl/positional_list_queue_unit_assert.svh
// Assertion helpers shared by the checked modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef POSITIONAL_LIST_QUEUE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/plq_pkg.sv
package plq_pkg;

  localparam int unsigned INSERT_AFTER = 3;

  localparam logic [2:0] CMD_PUSH_BACK    = 3'd0;
  localparam logic [2:0] CMD_POP_FRONT    = 3'd1;
  localparam logic [2:0] CMD_PUSH_FRONT   = 3'd2;
  localparam logic [2:0] CMD_INSERT_THIRD = 3'd3;
  localparam logic [2:0] CMD_REMOVE_KTH   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_FEW    = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INS,
    KIND_REM
  } plq_kind_t;

  typedef struct packed {
    plq_kind_t  kind;
    logic [1:0] status;
  } plq_plan_t;

endpackage

### rtl/positional_list_queue_unit.sv
// Ordered list of up to DEPTH signed words in one single-port-read RAM. Each request
// (push back, pop front, push front, insert after the third word, remove the k-th word)
// returns one response with a status, the removed word and the new fill. The words
// behind the target slot are moved one place per cycle through the RAM's registered
// read port; an insert then writes the new word into the target slot. in_ready is high
// only while no request is being worked on; a finished response waits in the output
// register.
`include "positional_list_queue_unit_assert.svh"

module positional_list_queue_unit import plq_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic signed [31:0] value,
  input  logic [7:0]         position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] data_out,
  output logic [7:0]         fill
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_PUT   = 4'b0100,
    S_RESP  = 4'b1000
  } plq_state_t;

  plq_state_t    state;
  logic [CW-1:0] occ;
  plq_kind_t     kind;
  logic [1:0]    st;
  logic [31:0]   word;
  logic [AW-1:0] at;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] rd_left;
  logic          first;
  logic          pend;
  logic          pend_keep;
  logic [AW-1:0] pend_dst;
  logic [31:0]   removed;

  plq_plan_t     plan;
  logic [AW-1:0] dec_at;
  logic [CW-1:0] dec_moves;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [31:0]   ram_rdata;

  plq_decode #(.DEPTH(DEPTH)) u_decode (
    .command  (command),
    .position (position),
    .occ      (occ),
    .plan     (plan),
    .at       (dec_at),
    .moves    (dec_moves)
  );

  plq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);

  // A word read in one cycle is written to its neighbor slot in the next; the first
  // word read by a removal is the removed word and is kept instead of written.
  assign ram_re    = (state == S_SHIFT) && (rd_left != '0);
  assign ram_we    = ((state == S_SHIFT) && pend && !pend_keep) || (state == S_PUT);
  assign ram_waddr = (state == S_PUT) ? at : pend_dst;
  assign ram_wdata = (state == S_PUT) ? word : ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      pend_keep <= 1'b0;
      first     <= 1'b0;
      rd_left   <= '0;
      kind      <= KIND_NONE;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind    <= plan.kind;
            st      <= plan.status;
            word    <= value;
            at      <= dec_at;
            rd_left <= dec_moves;
            rd_ptr  <= (plan.kind == KIND_INS) ? AW'(occ - CW'(1)) : dec_at;
            first   <= 1'b1;
            pend    <= 1'b0;
            removed <= '0;
            state   <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          pend <= (rd_left != '0);
          if (rd_left != '0) begin
            pend_keep <= first && (kind == KIND_REM);
            first     <= 1'b0;
            if (kind == KIND_INS) begin
              pend_dst <= rd_ptr + AW'(1);
              rd_ptr   <= rd_ptr - AW'(1);
            end else begin
              pend_dst <= rd_ptr - AW'(1);
              rd_ptr   <= rd_ptr + AW'(1);
            end
            rd_left <= rd_left - CW'(1);
          end
          if (pend && pend_keep) begin
            removed <= ram_rdata;
          end
          if ((rd_left == '0) && !pend) begin
            if (kind == KIND_INS) begin
              state <= S_PUT;
            end else begin
              if (kind == KIND_REM) begin
                occ <= occ - CW'(1);
              end
              state <= S_RESP;
            end
          end
        end
        S_PUT: begin
          occ   <= occ + CW'(1);
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= st;
            data_out  <= removed;
            fill      <= 8'(occ);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PLQ_ASSERT_SAME(a_occ_bound, 1'b1, occ <= CW'(DEPTH), "element count above depth")
  `PLQ_ASSERT_SAME(a_no_rw_clash, ram_we && ram_re, ram_waddr != rd_ptr,
                   "shift writes the slot it is reading")
  `PLQ_ASSERT_SAME(a_full_fill, out_valid && (status == ST_FULL), fill == 8'(DEPTH),
                   "full status with a list that is not full")
  `PLQ_ASSERT_SAME(a_data_ok, out_valid && (data_out != '0), status == ST_OK,
                   "removed word returned on a failed request")

endmodule

### rtl/plq_ram.sv
module plq_ram import plq_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/plq_decode.sv
module plq_decode import plq_pkg::*; #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic [2:0]    command,
  input  logic [7:0]    position,
  input  logic [CW-1:0] occ,
  output plq_plan_t     plan,
  output logic [AW-1:0] at,
  output logic [CW-1:0] moves
);

  localparam int CMPW = (CW > 8) ? CW : 8;

  logic            full;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] occ_ext;
  logic            bad_pos;

  assign full    = (occ == CW'(DEPTH));
  assign pos_ext = CMPW'(position);
  assign occ_ext = CMPW'(occ);
  assign bad_pos = (pos_ext == '0) || (pos_ext > occ_ext);

  always_comb begin
    plan.kind   = KIND_NONE;
    plan.status = ST_OK;
    at          = '0;
    case (command)
      CMD_PUSH_BACK: begin
        if (full) begin
          plan.status = ST_FULL;
        end else begin
          plan.kind = KIND_INS;
          at        = AW'(occ);
        end
      end
      CMD_POP_FRONT: begin
        if (occ == '0) begin
          plan.status = ST_FEW;
        end else begin
          plan.kind = KIND_REM;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          plan.status = ST_FULL;
        end else begin
          plan.kind = KIND_INS;
        end
      end
      CMD_INSERT_THIRD: begin
        if (full) begin
          plan.status = ST_FULL;
        end else if (occ < CW'(INSERT_AFTER)) begin
          plan.status = ST_FEW;
        end else begin
          plan.kind = KIND_INS;
          at        = AW'(INSERT_AFTER);
        end
      end
      CMD_REMOVE_KTH: begin
        if (occ == '0) begin
          plan.status = ST_FEW;
        end else if (bad_pos) begin
          plan.status = ST_BADPOS;
        end else begin
          plan.kind = KIND_REM;
          at        = AW'(pos_ext - CMPW'(1));
        end
      end
      default: begin
        plan.kind = KIND_NONE;
      end
    endcase
  end

  // Both an insert and a removal touch every word from the target slot to the tail.
  assign moves = (plan.kind == KIND_NONE) ? '0 : (occ - CW'(at));

endmodule
